// File: sv/rob_pkg.sv
package rob_pkg;

    localparam int COORD_BITS  = 10;
    localparam int ADDR_BITS   = 22;
    localparam int PITCH_SHIFT = 2;

    localparam int PITCH_W  = COORD_BITS + PITCH_SHIFT;
    localparam int CORNER_W = 2 * COORD_BITS;
    localparam int PROD_W   = COORD_BITS + PITCH_W;
    localparam int SUM_W    = ((PROD_W > ADDR_BITS) ? PROD_W : ADDR_BITS) + 1;

    localparam int PIX_W     = 8;
    localparam int MODE_W    = 3;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    // Raster modes.
    localparam logic [MODE_W-1:0] MODE_PUT         = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUT_KEEP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OVERLAY_KEEP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OVERLAY     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OR          = 3'd4;
    localparam logic [MODE_W-1:0] MODE_AND_NOT     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_PLANAR      = 3'd6;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_CORNER = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_CORNER = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SRC_PITCH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DST_PITCH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 3'd6;

    localparam logic [COORD_BITS-1:0] SRC_PITCH_RESET = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0] DST_PITCH_RESET = COORD_BITS'(160);

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [PIX_W-1:0] KEEP_BIT = 8'h40;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [CORNER_W-1:0]   src_corner;
        logic [CORNER_W-1:0]   dst_corner;
        logic [COORD_BITS-1:0] src_pitch;
        logic [COORD_BITS-1:0] dst_pitch;
        logic [COORD_BITS-1:0] rect_width;
        logic [COORD_BITS-1:0] rect_height;
    } rob_cfg_t;

    // Address of a corner: x plus y times the line pitch, wrapped.
    function automatic logic [ADDR_BITS-1:0] origin(
        input logic [CORNER_W-1:0] corner,
        input logic [PITCH_W-1:0]  pitch
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(corner[CORNER_W-1:COORD_BITS]) * SUM_W'(pitch)
            + SUM_W'(corner[COORD_BITS-1:0]);
        return sum[ADDR_BITS-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] addr_add(
        input logic [ADDR_BITS-1:0] base,
        input logic [PITCH_W-1:0]   offset
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

// File: sv/rob_regs.sv
module rob_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rob_pkg::PADDR_W-1:0]      paddr,
    input  logic [rob_pkg::PDATA_W-1:0]      pwdata,
    output logic [rob_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    output rob_pkg::rob_cfg_t                cfg
);

    rob_pkg::rob_cfg_t                 cfg_reg;
    logic [rob_pkg::REG_IDX_W-1:0]     idx;
    logic                              wr;

    assign idx    = paddr[rob_pkg::PADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= rob_pkg::MODE_PUT;
            cfg_reg.src_corner  <= '0;
            cfg_reg.dst_corner  <= '0;
            cfg_reg.src_pitch   <= rob_pkg::SRC_PITCH_RESET;
            cfg_reg.dst_pitch   <= rob_pkg::DST_PITCH_RESET;
            cfg_reg.rect_width  <= '0;
            cfg_reg.rect_height <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                rob_pkg::REG_MODE:
                    cfg_reg.mode <= pwdata[rob_pkg::MODE_W-1:0];
                rob_pkg::REG_SRC_CORNER:
                    cfg_reg.src_corner <= pwdata[rob_pkg::CORNER_W-1:0];
                rob_pkg::REG_DST_CORNER:
                    cfg_reg.dst_corner <= pwdata[rob_pkg::CORNER_W-1:0];
                rob_pkg::REG_SRC_PITCH:
                    cfg_reg.src_pitch <= pwdata[rob_pkg::COORD_BITS-1:0];
                rob_pkg::REG_DST_PITCH:
                    cfg_reg.dst_pitch <= pwdata[rob_pkg::COORD_BITS-1:0];
                rob_pkg::REG_WIDTH:
                    cfg_reg.rect_width <= pwdata[rob_pkg::COORD_BITS-1:0];
                rob_pkg::REG_HEIGHT:
                    cfg_reg.rect_height <= pwdata[rob_pkg::COORD_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rob_pkg::REG_MODE:       prdata = rob_pkg::PDATA_W'(cfg_reg.mode);
            rob_pkg::REG_SRC_CORNER: prdata = rob_pkg::PDATA_W'(cfg_reg.src_corner);
            rob_pkg::REG_DST_CORNER: prdata = rob_pkg::PDATA_W'(cfg_reg.dst_corner);
            rob_pkg::REG_SRC_PITCH:  prdata = rob_pkg::PDATA_W'(cfg_reg.src_pitch);
            rob_pkg::REG_DST_PITCH:  prdata = rob_pkg::PDATA_W'(cfg_reg.dst_pitch);
            rob_pkg::REG_WIDTH:      prdata = rob_pkg::PDATA_W'(cfg_reg.rect_width);
            rob_pkg::REG_HEIGHT:     prdata = rob_pkg::PDATA_W'(cfg_reg.rect_height);
            default:                 prdata = '0;
        endcase
    end

endmodule

// File: sv/rob_core.sv
module rob_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rob_pkg::rob_cfg_t                   cfg,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [rob_pkg::PIX_W-1:0]           src_pixel,
    input  logic [rob_pkg::PIX_W-1:0]           dst_pixel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rob_pkg::ADDR_BITS-1:0]       write_addr,
    output logic [rob_pkg::PIX_W-1:0]           write_data,
    output logic                                write_enable,
    output logic [rob_pkg::ADDR_BITS-1:0]       next_src_addr,
    output logic [rob_pkg::ADDR_BITS-1:0]       next_dst_addr,
    output logic                                done_res
);

    localparam int AW = rob_pkg::ADDR_BITS;
    localparam int CW = rob_pkg::COORD_BITS;
    localparam int PW = rob_pkg::PITCH_W;
    localparam int XW = rob_pkg::PIX_W;

    // Input register.
    logic            s1_valid_reg;
    logic            s1_req_reg;
    logic [XW-1:0]   s1_src_reg;
    logic [XW-1:0]   s1_dst_reg;

    // Walk state.
    logic [CW-1:0]   col_reg, col_next;
    logic [CW-1:0]   rows_reg, rows_next;
    logic [AW-1:0]   sbase_reg, sbase_next;
    logic [AW-1:0]   dbase_reg, dbase_next;
    logic            active_reg, active_next;

    // Result register.
    logic            out_valid_reg;
    logic [AW-1:0]   waddr_reg, waddr_next;
    logic [XW-1:0]   wdata_reg, wdata_next;
    logic            we_reg, we_next;
    logic [AW-1:0]   nsrc_reg, nsrc_next;
    logic [AW-1:0]   ndst_reg, ndst_next;
    logic            done_reg, done_next;

    logic            out_free;
    logic            step;
    logic            accept;
    logic [PW-1:0]   eff_sp;
    logic [PW-1:0]   eff_dp;
    logic [CW-1:0]   x;
    logic [XW:0]     rop;

    // Combines one pixel pair; the top bit is the write enable.
    function automatic logic [XW:0] raster_op(
        input logic [rob_pkg::MODE_W-1:0] mode,
        input logic [XW-1:0]              s,
        input logic [XW-1:0]              d
    );
        logic          nz;
        logic [XW:0]   res;
        nz  = (s != '0);
        res = {1'b0, d};
        unique case (mode)
            rob_pkg::MODE_PUT_KEEP:
                res = {1'b1, s | (d & rob_pkg::KEEP_BIT)};
            rob_pkg::MODE_OVERLAY_KEEP:
                if (nz)
                    res = {1'b1, s | (d & rob_pkg::KEEP_BIT)};
            rob_pkg::MODE_OVERLAY:
                if (nz)
                    res = {1'b1, s};
            rob_pkg::MODE_OR:
                if (nz)
                    res = {1'b1, d | s};
            rob_pkg::MODE_AND_NOT:
                if (nz)
                    res = {1'b1, d & ~s};
            default:
                res = {1'b1, s};
        endcase
        return res;
    endfunction

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign eff_sp = (cfg.mode == rob_pkg::MODE_PLANAR)
                  ? (PW'(cfg.src_pitch) << rob_pkg::PITCH_SHIFT) : PW'(cfg.src_pitch);
    assign eff_dp = (cfg.mode == rob_pkg::MODE_PLANAR)
                  ? PW'(cfg.dst_pitch) : (PW'(cfg.dst_pitch) << rob_pkg::PITCH_SHIFT);

    assign x   = col_reg - 1'b1;
    assign rop = raster_op(cfg.mode, s1_src_reg, s1_dst_reg);

    always_comb
    begin
        col_next    = col_reg;
        rows_next   = rows_reg;
        sbase_next  = sbase_reg;
        dbase_next  = dbase_reg;
        active_next = active_reg;
        waddr_next  = '0;
        wdata_next  = '0;
        we_next     = 1'b0;

        if (s1_req_reg == rob_pkg::REQ_START)
        begin
            sbase_next  = rob_pkg::origin(cfg.src_corner, eff_sp);
            dbase_next  = rob_pkg::origin(cfg.dst_corner, eff_dp);
            col_next    = cfg.rect_width;
            rows_next   = cfg.rect_height;
            active_next = (cfg.rect_width != '0) && (cfg.rect_height != '0);
        end
        else if (active_reg && (col_reg != '0))
        begin
            waddr_next = rob_pkg::addr_add(dbase_reg, PW'(x));
            wdata_next = rop[XW-1:0];
            we_next    = rop[XW];
            col_next   = x;
            // Last column of the row: step both bases down one line.
            if (x == '0)
            begin
                rows_next  = rows_reg - 1'b1;
                sbase_next = rob_pkg::addr_add(sbase_reg, eff_sp);
                dbase_next = rob_pkg::addr_add(dbase_reg, eff_dp);
                col_next   = cfg.rect_width;
                if ((rows_next == '0) || (cfg.rect_width == '0))
                    active_next = 1'b0;
            end
        end

        if (active_next && (col_next != '0))
        begin
            nsrc_next = rob_pkg::addr_add(sbase_next, PW'(col_next - 1'b1));
            ndst_next = rob_pkg::addr_add(dbase_next, PW'(col_next - 1'b1));
            done_next = 1'b0;
        end
        else
        begin
            active_next = 1'b0;
            nsrc_next   = '0;
            ndst_next   = '0;
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            rows_reg      <= '0;
            sbase_reg     <= '0;
            dbase_reg     <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (step)
                s1_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (step)
            begin
                col_reg    <= col_next;
                rows_reg   <= rows_next;
                sbase_reg  <= sbase_next;
                dbase_reg  <= dbase_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req_type;
            s1_src_reg <= src_pixel;
            s1_dst_reg <= dst_pixel;
        end
        if (step)
        begin
            waddr_reg <= waddr_next;
            wdata_reg <= wdata_next;
            we_reg    <= we_next;
            nsrc_reg  <= nsrc_next;
            ndst_reg  <= ndst_next;
            done_reg  <= done_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_addr    = waddr_reg;
    assign write_data    = wdata_reg;
    assign write_enable  = we_reg;
    assign next_src_addr = nsrc_reg;
    assign next_dst_addr = ndst_reg;
    assign done_res      = done_reg;

endmodule

// File: sv/raster_op_blitter_unit.sv
// Channel   Direction  Handshake            Beat contents
// input     in         in_valid / in_stall  req_type, src_pixel, dst_pixel
// output    out        out_valid/out_stall  write_addr, write_data, write_enable,
//                                           next_src_addr, next_dst_addr, done_res
// config    in         APB psel/penable     mode .. rect_height at paddr 4*i
//
// Every input beat yields one output beat, loaded into the result register at the
// first edge after it is accepted at which the result register is free.
// One beat per cycle is sustained while out_stall is low; the walk-state update
// and the corner multiply are combinational and feed the result register directly.
// Reset clears the walk state and leaves the block idle; pitches reset to 320/160.
// An input beat is still taken while a result waits, until the input register fills.
module raster_op_blitter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rob_pkg::PADDR_W-1:0]         paddr,
    input  logic [rob_pkg::PDATA_W-1:0]         pwdata,
    output logic [rob_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [rob_pkg::PIX_W-1:0]           src_pixel,
    input  logic [rob_pkg::PIX_W-1:0]           dst_pixel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rob_pkg::ADDR_BITS-1:0]       write_addr,
    output logic [rob_pkg::PIX_W-1:0]           write_data,
    output logic                                write_enable,
    output logic [rob_pkg::ADDR_BITS-1:0]       next_src_addr,
    output logic [rob_pkg::ADDR_BITS-1:0]       next_dst_addr,
    output logic                                done_res
);

    rob_pkg::rob_cfg_t cfg;

    rob_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rob_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .src_pixel     (src_pixel),
        .dst_pixel     (dst_pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_addr    (write_addr),
        .write_data    (write_data),
        .write_enable  (write_enable),
        .next_src_addr (next_src_addr),
        .next_dst_addr (next_dst_addr),
        .done_res      (done_res)
    );

endmodule

// File: tb/raster_op_blitter_unit_tb.sv
`timescale 1ns / 100ps

module raster_op_blitter_unit_tb;

    import rob_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;
    localparam int MAX_SHOWN   = 40;

    // The mode field has room for one code that the package does not name.
    localparam logic [MODE_W-1:0] MODE_UNDEFINED = 3'd7;

    typedef struct packed {
        logic [ADDR_BITS-1:0] waddr;
        logic [PIX_W-1:0]     wdata;
        logic                 wen;
        logic [ADDR_BITS-1:0] src_next;
        logic [ADDR_BITS-1:0] dst_next;
        logic                 done;
    } write_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_stall;
    logic                   req_type;
    logic [PIX_W-1:0]       src_pixel;
    logic [PIX_W-1:0]       dst_pixel;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [ADDR_BITS-1:0]   write_addr;
    logic [PIX_W-1:0]       write_data;
    logic                   write_enable;
    logic [ADDR_BITS-1:0]   next_src_addr;
    logic [ADDR_BITS-1:0]   next_dst_addr;
    logic                   done_res;

    raster_op_blitter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .src_pixel     (src_pixel),
        .dst_pixel     (dst_pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_addr    (write_addr),
        .write_data    (write_data),
        .write_enable  (write_enable),
        .next_src_addr (next_src_addr),
        .next_dst_addr (next_dst_addr),
        .done_res      (done_res)
    );

    always #6 clk = ~clk;

    // Shadow copy of the registers and of the rectangle walk.
    rob_cfg_t             shadow;
    logic [COORD_BITS-1:0] cols_left;
    logic [COORD_BITS-1:0] rows_todo;
    logic [ADDR_BITS-1:0]  src_base;
    logic [ADDR_BITS-1:0]  dst_base;
    logic                  walking;

    write_beat_t pending_writes[$];
    write_beat_t head_write;

    int mismatches   = 0;
    int beats_sent   = 0;
    int results_seen = 0;
    int blit_starts  = 0;
    int cycle_count  = 0;

    // Idling knobs: gaps and bursts for the sender, stalls for the receiver.
    int gap_max    = 3;
    int stall_pct  = 30;
    int burst_left = 0;
    int stall_run  = 0;
    logic stall_hold = 1'b0;

    function automatic logic [PITCH_W-1:0] src_stride();
        if (shadow.mode == MODE_PLANAR)
            return PITCH_W'(shadow.src_pitch) << PITCH_SHIFT;
        return PITCH_W'(shadow.src_pitch);
    endfunction

    function automatic logic [PITCH_W-1:0] dst_stride();
        if (shadow.mode == MODE_PLANAR)
            return PITCH_W'(shadow.dst_pitch);
        return PITCH_W'(shadow.dst_pitch) << PITCH_SHIFT;
    endfunction

    function automatic logic [ADDR_BITS-1:0] corner_addr(input logic [CORNER_W-1:0] corner,
                                                         input logic [PITCH_W-1:0] pitch);
        logic [63:0] full;
        full = 64'(corner[CORNER_W-1:COORD_BITS]) * 64'(pitch) + 64'(corner[COORD_BITS-1:0]);
        return full[ADDR_BITS-1:0];
    endfunction

    function automatic void reset_shadow();
        shadow.mode        = MODE_PUT;
        shadow.src_corner  = '0;
        shadow.dst_corner  = '0;
        shadow.src_pitch   = SRC_PITCH_RESET;
        shadow.dst_pitch   = DST_PITCH_RESET;
        shadow.rect_width  = '0;
        shadow.rect_height = '0;
        cols_left = '0;
        rows_todo = '0;
        src_base  = '0;
        dst_base  = '0;
        walking   = 1'b0;
    endfunction

    function automatic void set_shadow_reg(input logic [REG_IDX_W-1:0] idx,
                                           input logic [PDATA_W-1:0] value);
        case (idx)
            REG_MODE:       shadow.mode        = value[MODE_W-1:0];
            REG_SRC_CORNER: shadow.src_corner  = value[CORNER_W-1:0];
            REG_DST_CORNER: shadow.dst_corner  = value[CORNER_W-1:0];
            REG_SRC_PITCH:  shadow.src_pitch   = value[COORD_BITS-1:0];
            REG_DST_PITCH:  shadow.dst_pitch   = value[COORD_BITS-1:0];
            REG_WIDTH:      shadow.rect_width  = value[COORD_BITS-1:0];
            REG_HEIGHT:     shadow.rect_height = value[COORD_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [PDATA_W-1:0] shadow_reg(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_MODE:       return PDATA_W'(shadow.mode);
            REG_SRC_CORNER: return PDATA_W'(shadow.src_corner);
            REG_DST_CORNER: return PDATA_W'(shadow.dst_corner);
            REG_SRC_PITCH:  return PDATA_W'(shadow.src_pitch);
            REG_DST_PITCH:  return PDATA_W'(shadow.dst_pitch);
            REG_WIDTH:      return PDATA_W'(shadow.rect_width);
            REG_HEIGHT:     return PDATA_W'(shadow.rect_height);
            default:        return '0;
        endcase
    endfunction

    // Steps the walk by one accepted beat and queues the write it produces.
    function automatic void advance_blit(input logic rt, input logic [PIX_W-1:0] s,
                                         input logic [PIX_W-1:0] d);
        write_beat_t b;
        logic [COORD_BITS-1:0] x;
        b = '0;
        if (rt == REQ_START) begin
            src_base  = corner_addr(shadow.src_corner, src_stride());
            dst_base  = corner_addr(shadow.dst_corner, dst_stride());
            cols_left = shadow.rect_width;
            rows_todo = shadow.rect_height;
            walking   = (cols_left != 0) && (rows_todo != 0);
            blit_starts++;
        end else if (walking && cols_left != 0) begin
            x = cols_left - 1'b1;
            b.waddr = dst_base + ADDR_BITS'(x);
            b.wdata = d;
            case (shadow.mode)
                MODE_PUT_KEEP: begin
                    b.wdata = s | (d & KEEP_BIT);
                    b.wen   = 1'b1;
                end
                MODE_OVERLAY_KEEP: if (s != 0) begin
                    b.wdata = s | (d & KEEP_BIT);
                    b.wen   = 1'b1;
                end
                MODE_OVERLAY: if (s != 0) begin
                    b.wdata = s;
                    b.wen   = 1'b1;
                end
                MODE_OR: if (s != 0) begin
                    b.wdata = d | s;
                    b.wen   = 1'b1;
                end
                MODE_AND_NOT: if (s != 0) begin
                    b.wdata = d & ~s;
                    b.wen   = 1'b1;
                end
                default: begin
                    b.wdata = s;
                    b.wen   = 1'b1;
                end
            endcase
            cols_left = x;
            if (cols_left == 0) begin
                // Row advance picks up whatever mode, pitch and width are set now.
                rows_todo = rows_todo - 1'b1;
                src_base  = src_base + ADDR_BITS'(src_stride());
                dst_base  = dst_base + ADDR_BITS'(dst_stride());
                cols_left = shadow.rect_width;
                if (rows_todo == 0 || cols_left == 0)
                    walking = 1'b0;
            end
        end
        if (walking && cols_left != 0) begin
            b.src_next = src_base + ADDR_BITS'(cols_left - 1'b1);
            b.dst_next = dst_base + ADDR_BITS'(cols_left - 1'b1);
        end else begin
            walking = 1'b0;
            b.done  = 1'b1;
        end
        pending_writes.push_back(b);
    endfunction

    task automatic check_field(input string what, input logic [PDATA_W-1:0] want,
                               input logic [PDATA_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: result beat with none pending, expected nothing, got 0x%0h",
                             $time, write_addr);
            end else begin
                head_write = pending_writes.pop_front();
                check_field("write_addr", PDATA_W'(head_write.waddr), PDATA_W'(write_addr));
                check_field("write_data", PDATA_W'(head_write.wdata), PDATA_W'(write_data));
                check_field("write_enable", PDATA_W'(head_write.wen),
                            PDATA_W'(write_enable));
                check_field("next_src_addr", PDATA_W'(head_write.src_next),
                            PDATA_W'(next_src_addr));
                check_field("next_dst_addr", PDATA_W'(head_write.dst_next),
                            PDATA_W'(next_dst_addr));
                check_field("done_res", PDATA_W'(head_write.done), PDATA_W'(done_res));
                results_seen++;
            end
        end
    end

    always @(negedge clk) begin
        if (stall_run == 0) begin
            stall_run  = $urandom_range(1, 12);
            stall_hold = (stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct);
        end
        stall_run--;
        out_stall = stall_hold;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("raster_op_blitter_unit test failed");
            $finish;
        end
    end

    // All stimulus tasks start and end just after a falling edge.
    task automatic send_beat(input logic rt, input logic [PIX_W-1:0] sp,
                             input logic [PIX_W-1:0] dp);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max != 0)
                repeat ($urandom_range(0, gap_max)) @(negedge clk);
        end
        burst_left--;
        req_type  = rt;
        src_pixel = sp;
        dst_pixel = dp;
        in_valid  = 1'b1;
        do @(posedge clk); while (in_stall);
        advance_blit(rt, sp, dp);
        beats_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        set_shadow_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [REG_IDX_W-1:0] idx, output logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_for_writes();
        while (pending_writes.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_src_byte();
        if ($urandom_range(0, 3) == 0)
            return '0;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic int pick_span(input int small_max);
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 1023;
            2:       return $urandom_range(0, 1023);
            default: return $urandom_range(1, small_max);
        endcase
    endfunction

    function automatic int pick_pitch();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1023;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic logic [PDATA_W-1:0] pick_corner();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'h000F_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_register_readback();
        logic [PDATA_W-1:0] got;
        int i;
        for (i = 0; i <= int'(REG_HEIGHT); i++) begin
            apb_read(REG_IDX_W'(i), got);
            check_field("register reset value", shadow_reg(REG_IDX_W'(i)), got);
        end
        for (i = 0; i <= int'(REG_HEIGHT); i++) begin
            apb_write(REG_IDX_W'(i), '1);
            apb_read(REG_IDX_W'(i), got);
            check_field("register readback", shadow_reg(REG_IDX_W'(i)), got);
        end
    endtask

    task automatic test_empty_and_idle();
        // A pixel beat with no blit running writes nothing and reports done.
        send_beat(REQ_PIXEL, 8'hFF, 8'hFF);
        wait_for_writes();
        apb_write(REG_MODE, PDATA_W'(MODE_PUT));
        apb_write(REG_WIDTH, 0);
        apb_write(REG_HEIGHT, 4);
        send_beat(REQ_START, 8'h00, 8'h00);
        send_beat(REQ_PIXEL, 8'h12, 8'h34);
        wait_for_writes();
        apb_write(REG_WIDTH, 5);
        apb_write(REG_HEIGHT, 0);
        send_beat(REQ_START, 8'hFF, 8'hFF);
        send_beat(REQ_PIXEL, 8'h56, 8'h78);
    endtask

    // One 12-pixel row with the mode rewritten before each pixel, so every
    // raster op sees both a zero and a nonzero source byte where that matters.
    // The last pixel also drops the width to zero, which ends the blit at reload.
    task automatic test_live_modes();
        logic [MODE_W-1:0] modes[12] = '{MODE_PUT, MODE_PUT_KEEP, MODE_OVERLAY_KEEP,
                                         MODE_OVERLAY_KEEP, MODE_OVERLAY, MODE_OVERLAY,
                                         MODE_OR, MODE_OR, MODE_AND_NOT, MODE_AND_NOT,
                                         MODE_PLANAR, MODE_UNDEFINED};
        logic [PIX_W-1:0] srcs[12] = '{8'hA5, 8'h81, 8'h00, 8'h0F, 8'h00, 8'hFF,
                                       8'h00, 8'h01, 8'h00, 8'hF0, 8'h3C, 8'hFF};
        logic [PIX_W-1:0] dsts[12] = '{8'h5A, 8'h40, 8'h7F, 8'hC0, 8'h33, 8'h00,
                                       8'h80, 8'hFE, 8'hFF, 8'hFF, 8'hC3, 8'hFF};
        int i;
        wait_for_writes();
        apb_write(REG_MODE, PDATA_W'(MODE_PUT));
        apb_write(REG_SRC_CORNER, 32'h0000_2C05);
        apb_write(REG_DST_CORNER, 32'h0000_1403);
        apb_write(REG_SRC_PITCH, 320);
        apb_write(REG_DST_PITCH, 160);
        apb_write(REG_WIDTH, 12);
        apb_write(REG_HEIGHT, 2);
        send_beat(REQ_START, 8'h00, 8'h00);
        for (i = 0; i < 12; i++) begin
            wait_for_writes();
            apb_write(REG_MODE, PDATA_W'(modes[i]));
            if (i == 11) begin
                apb_write(REG_DST_PITCH, 1023);
                apb_write(REG_WIDTH, 0);
            end
            send_beat(REQ_PIXEL, srcs[i], dsts[i]);
        end
        send_beat(REQ_PIXEL, 8'h77, 8'h88);
    endtask

    task automatic test_address_extremes();
        wait_for_writes();
        apb_write(REG_MODE, PDATA_W'(MODE_PLANAR));
        apb_write(REG_SRC_CORNER, 32'h000F_FFFF);
        apb_write(REG_DST_CORNER, 32'h000F_FFFF);
        apb_write(REG_SRC_PITCH, 1023);
        apb_write(REG_DST_PITCH, 1023);
        apb_write(REG_WIDTH, 1023);
        apb_write(REG_HEIGHT, 1023);
        send_beat(REQ_START, 8'h00, 8'h00);
        send_beat(REQ_PIXEL, 8'hFF, 8'hFF);
        send_beat(REQ_PIXEL, 8'h00, 8'h00);
        // A one-pixel-wide column whose destination rows wrap the address space.
        wait_for_writes();
        apb_write(REG_MODE, PDATA_W'(MODE_PUT));
        apb_write(REG_SRC_PITCH, 0);
        apb_write(REG_WIDTH, 1);
        apb_write(REG_HEIGHT, 3);
        send_beat(REQ_START, 8'hFF, 8'h00);
        repeat (3) send_beat(REQ_PIXEL, PIX_W'($urandom_range(0, 255)),
                             PIX_W'($urandom_range(0, 255)));
        send_beat(REQ_PIXEL, 8'h00, 8'hFF);
    endtask

    task automatic test_random_blits(input int target);
        int w;
        int h;
        int n;
        int k;
        while (beats_sent < target) begin
            wait_for_writes();
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 70);
            apb_write(REG_MODE, $urandom_range(0, 7));
            apb_write(REG_SRC_CORNER, pick_corner());
            apb_write(REG_DST_CORNER, pick_corner());
            apb_write(REG_SRC_PITCH, pick_pitch());
            apb_write(REG_DST_PITCH, pick_pitch());
            w = pick_span(8);
            h = pick_span(5);
            apb_write(REG_WIDTH, w);
            apb_write(REG_HEIGHT, h);
            if ($urandom_range(0, 11) == 0) begin
                // Loose beats of either kind in no particular order.
                repeat (10) send_beat(1'($urandom_range(0, 1)),
                                      PIX_W'($urandom_range(0, 255)),
                                      PIX_W'($urandom_range(0, 255)));
            end else begin
                send_beat(REQ_START, PIX_W'($urandom_range(0, 255)),
                          PIX_W'($urandom_range(0, 255)));
                n = w * h;
                if (n > 40)
                    n = $urandom_range(5, 40);
                for (k = 0; k < n; k++) begin
                    case ($urandom_range(0, 39))
                        0: send_beat(REQ_START, PIX_W'($urandom_range(0, 255)),
                                     PIX_W'($urandom_range(0, 255)));
                        1: begin
                            // Let the pipe empty mid-blit, then change a live register.
                            wait_for_writes();
                            case ($urandom_range(0, 3))
                                0: apb_write(REG_MODE, $urandom_range(0, 7));
                                1: apb_write(REG_SRC_PITCH, pick_pitch());
                                2: apb_write(REG_DST_PITCH, pick_pitch());
                                default: apb_write(REG_WIDTH, pick_span(8));
                            endcase
                        end
                        default: ;
                    endcase
                    send_beat(REQ_PIXEL, rand_src_byte(), PIX_W'($urandom_range(0, 255)));
                end
                repeat ($urandom_range(0, 2))
                    send_beat(REQ_PIXEL, rand_src_byte(), PIX_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        req_type  = REQ_START;
        src_pixel = '0;
        dst_pixel = '0;
        reset_shadow();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_register_readback();
        test_empty_and_idle();
        test_live_modes();
        test_address_extremes();
        test_random_blits(1100);

        wait_for_writes();
        repeat (10) @(negedge clk);
        $display("Sent %0d input beats (%0d blit starts) and checked %0d result beats.",
                 beats_sent, blit_starts, results_seen);
        $display("Run covered all mode codes, empty and idle cases, live register changes, wrap.");
        if (mismatches == 0)
            $display("raster_op_blitter_unit test passed");
        else
            $display("raster_op_blitter_unit test failed");
        $finish;
    end

endmodule
